>>> sv/symmetric_tensor_rotation_unit_defines.svh
// ----------------------------------------------------------------------------
// Symmetric tensor rotation unit assertion macros
// Shared assertion shorthands for the rotation unit's checker.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_TENSOR_ROTATION_UNIT_DEFINES_SVH
`define SYMMETRIC_TENSOR_ROTATION_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STROT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("strot assertion failed: same-cycle rule");

// Consequent must hold in the cycle after the antecedent.
`define STROT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("strot assertion failed: next-cycle rule");

`endif

>>> sv/strot_pkg.sv
// ----------------------------------------------------------------------------
// Symmetric tensor rotation package
// Beat types, register indexes and default widths for the rotation unit.
// ----------------------------------------------------------------------------
package strot_pkg;

   // Tensor components are signed fixed point of this fixed width.
   localparam int DATA_WIDTH         = 32;
   localparam int COEF_WIDTH_DEFAULT = 18;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_ROT_ROW_X  = 2'd0,
      CSR_ROT_ROW_Y  = 2'd1,
      CSR_ROT_ROW_Z  = 2'd2,
      CSR_COORD_MODE = 2'd3
   } csr_index_type;

   // One input beat: the six unique components of a symmetric tensor.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] comp_first;
      logic signed [DATA_WIDTH-1:0] comp_second;
      logic signed [DATA_WIDTH-1:0] comp_third;
      logic signed [DATA_WIDTH-1:0] comp_fourth;
      logic signed [DATA_WIDTH-1:0] comp_fifth;
      logic signed [DATA_WIDTH-1:0] comp_sixth;
   } req_beat_type;

   // One result beat: the rotated components and the clip flag.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] res_first;
      logic signed [DATA_WIDTH-1:0] res_second;
      logic signed [DATA_WIDTH-1:0] res_third;
      logic signed [DATA_WIDTH-1:0] res_fourth;
      logic signed [DATA_WIDTH-1:0] res_fifth;
      logic signed [DATA_WIDTH-1:0] res_sixth;
      logic                         saturated;
   } rsp_beat_type;

endpackage

>>> sv/symmetric_tensor_rotation_unit.sv
// The unit accepts one symmetric tensor beat in every clock cycle while
// req_stall is low and returns R * A * R^T from its last stage. The six
// stages are: input mapping, the first matrix product (27 multipliers), its
// sums and rounding, the second matrix product (27 multipliers), its sums and
// rounding, and output mapping with clipping. Each stage has its own valid
// bit, so a stalled result holds only the stages behind it that are full and
// the input keeps flowing into empty stages. Registers are written through
// the csr port, which is always ready, and should only change while no beat
// is in flight.
// ----------------------------------------------------------------------------
// Symmetric tensor rotation unit
// Rotates a symmetric 3x3 tensor by a configured matrix, in cartesian or
// spherical component order, with rounding and saturation.
// ----------------------------------------------------------------------------
module symmetric_tensor_rotation_unit #(
   parameter int COEF_WIDTH = strot_pkg::COEF_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = strot_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  strot_pkg::req_beat_type   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output strot_pkg::rsp_beat_type   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  strot_pkg::csr_index_type  csr_index,
   input  logic [3*COEF_WIDTH-1:0]   csr_wdata
);

   localparam int DW     = strot_pkg::DATA_WIDTH;
   localparam int AW     = DW + 1;                 // input after exact negation
   localparam int ROW_W  = 3 * COEF_WIDTH;
   localparam int P1_W   = AW + COEF_WIDTH;
   localparam int S1_W   = P1_W + 2;
   localparam int TW     = S1_W - FRAC_BITS;       // intermediate product width
   localparam int P2_W   = COEF_WIDTH + TW;
   localparam int S2_W   = P2_W + 2;
   localparam int OW     = S2_W - FRAC_BITS;       // rounded result width
   localparam int NW     = OW + 1;                 // rounded result after negation
   localparam int STAGES = 6;

   localparam logic [S1_W-1:0] HALF1 = S1_W'(1) << (FRAC_BITS - 1);
   localparam logic [S2_W-1:0] HALF2 = S2_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [NW-1:0] RES_MAX =
      signed'({{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}});
   localparam logic signed [NW-1:0] RES_MIN =
      signed'({{(NW-DW+1){1'b1}}, {(DW-1){1'b0}}});

   // Position of A[i][k] among the six unique components.
   localparam int SYM_IDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [ROW_W-1:0]             rot_row_ff [3];
   logic                         mode_ff;
   logic signed [COEF_WIDTH-1:0] coef [3][3];

   assign csr_ready = 1'b1;

   // Rows reset to the identity; writes land on the indexed register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            rot_row_ff[r] <= ROW_W'(1) << (FRAC_BITS + r * COEF_WIDTH);
         end
         mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            strot_pkg::CSR_ROT_ROW_X: begin
               rot_row_ff[0] <= csr_wdata;
            end
            strot_pkg::CSR_ROT_ROW_Y: begin
               rot_row_ff[1] <= csr_wdata;
            end
            strot_pkg::CSR_ROT_ROW_Z: begin
               rot_row_ff[2] <= csr_wdata;
            end
            strot_pkg::CSR_COORD_MODE: begin
               mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Unpack the matrix entries from the row registers.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            coef[i][j] = signed'(rot_row_ff[i][j*COEF_WIDTH +: COEF_WIDTH]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or moves on
   // ---------------------------------------------------------------------
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES:0]   load;

   always_comb begin
      load[STAGES] = !rsp_stall;
      for (int s = STAGES - 1; s >= 0; s--) begin
         load[s] = !vld_ff[s] || load[s+1];
      end
      vld_in[0] = req_valid;
      for (int s = 1; s < STAGES; s++) begin
         vld_in[s] = vld_ff[s-1];
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = vld_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (load[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: map components onto the unique tensor entries
   // Entry order: a00, a01, a02, a11, a12, a22.
   // ---------------------------------------------------------------------
   logic signed [AW-1:0] comp [6];
   logic signed [AW-1:0] a_in [6];
   logic signed [AW-1:0] a_ff [6];

   always_comb begin
      comp[0] = AW'(req_data.comp_first);
      comp[1] = AW'(req_data.comp_second);
      comp[2] = AW'(req_data.comp_third);
      comp[3] = AW'(req_data.comp_fourth);
      comp[4] = AW'(req_data.comp_fifth);
      comp[5] = AW'(req_data.comp_sixth);
      if (mode_ff) begin
         // Spherical order; components with one theta index change sign.
         a_in[5] = comp[0];
         a_in[4] = -comp[1];
         a_in[2] = comp[2];
         a_in[3] = comp[3];
         a_in[1] = -comp[4];
         a_in[0] = comp[5];
      end else begin
         for (int n = 0; n < 6; n++) begin
            a_in[n] = comp[n];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         a_ff <= a_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: products A[i][k] * R[j][k]
   // ---------------------------------------------------------------------
   logic signed [P1_W-1:0] p1_in [3][3][3];
   logic signed [P1_W-1:0] p1_ff [3][3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               p1_in[i][j][k] = a_ff[SYM_IDX[i][k]] * coef[j][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         p1_ff <= p1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: T[i][j] = round(sum over k), kept at full width
   // ---------------------------------------------------------------------
   logic [S1_W-1:0]      sum1 [3][3];
   logic signed [TW-1:0] t_in [3][3];
   logic signed [TW-1:0] t_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum1[i][j] = S1_W'(p1_ff[i][j][0]) + S1_W'(p1_ff[i][j][1])
                       + S1_W'(p1_ff[i][j][2]) + HALF1;
            t_in[i][j] = signed'(sum1[i][j][S1_W-1:FRAC_BITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         t_ff <= t_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: products R[i][k] * T[k][j]
   // ---------------------------------------------------------------------
   logic signed [P2_W-1:0] p2_in [3][3][3];
   logic signed [P2_W-1:0] p2_ff [3][3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               p2_in[i][j][k] = coef[i][k] * t_ff[k][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         p2_ff <= p2_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: O[i][j] = round(sum over k)
   // ---------------------------------------------------------------------
   logic [S2_W-1:0]      sum2 [3][3];
   logic signed [OW-1:0] o_in [3][3];
   logic signed [OW-1:0] o_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum2[i][j] = S2_W'(p2_ff[i][j][0]) + S2_W'(p2_ff[i][j][1])
                       + S2_W'(p2_ff[i][j][2]) + HALF2;
            o_in[i][j] = signed'(sum2[i][j][S2_W-1:FRAC_BITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         o_ff <= o_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: pick the result entries, flip signs, clip to the data range
   // ---------------------------------------------------------------------
   logic signed [NW-1:0] pick [6];
   logic signed [DW-1:0] res  [6];
   logic [5:0]           clip;
   strot_pkg::rsp_beat_type rsp_in;
   strot_pkg::rsp_beat_type rsp_ff;

   always_comb begin
      if (mode_ff) begin
         // Spherical results come from the lower triangle.
         pick[0] = NW'(o_ff[2][2]);
         pick[1] = -NW'(o_ff[2][1]);
         pick[2] = NW'(o_ff[2][0]);
         pick[3] = NW'(o_ff[1][1]);
         pick[4] = -NW'(o_ff[1][0]);
         pick[5] = NW'(o_ff[0][0]);
      end else begin
         pick[0] = NW'(o_ff[0][0]);
         pick[1] = NW'(o_ff[0][1]);
         pick[2] = NW'(o_ff[0][2]);
         pick[3] = NW'(o_ff[1][1]);
         pick[4] = NW'(o_ff[1][2]);
         pick[5] = NW'(o_ff[2][2]);
      end
      for (int n = 0; n < 6; n++) begin
         if (pick[n] > RES_MAX) begin
            res[n]  = RES_MAX[DW-1:0];
            clip[n] = 1'b1;
         end else if (pick[n] < RES_MIN) begin
            res[n]  = RES_MIN[DW-1:0];
            clip[n] = 1'b1;
         end else begin
            res[n]  = pick[n][DW-1:0];
            clip[n] = 1'b0;
         end
      end
      rsp_in.res_first  = res[0];
      rsp_in.res_second = res[1];
      rsp_in.res_third  = res[2];
      rsp_in.res_fourth = res[3];
      rsp_in.res_fifth  = res[4];
      rsp_in.res_sixth  = res[5];
      rsp_in.saturated  = |clip;
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sv/strot_checker.sv
// ----------------------------------------------------------------------------
// Symmetric tensor rotation checker
// Port-level assertions on the rotation unit's flow control.
// ----------------------------------------------------------------------------
`include "symmetric_tensor_rotation_unit_defines.svh"

module strot_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input strot_pkg::rsp_beat_type rsp_data
);

   // An input beat may arrive at any time; req_offer marks a beat that is taken.
   logic req_offer;
   assign req_offer = req_valid && !req_stall;

   // With the result side draining, every stage advances and input is taken.
   `STROT_ASSERT_NOW(a_flow_through, clock, reset, !rsp_stall, !req_stall)

   // An empty output stage lets the whole pipeline advance.
   `STROT_ASSERT_NOW(a_empty_accepts, clock, reset, !rsp_valid || req_offer, !req_stall)

   // A stalled result beat stays put until it is taken.
   `STROT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Reset empties the pipeline.
   `STROT_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind symmetric_tensor_rotation_unit strot_checker u_strot_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
